// File: rtl/slotted_page_tuple_store_core_assert.svh
// Assertion macros shared by the tuple store RTL.
// Included by the modules that carry concurrent checks; needs nothing else.
`ifndef SLOTTED_PAGE_TUPLE_STORE_CORE_ASSERT_SVH
`define SLOTTED_PAGE_TUPLE_STORE_CORE_ASSERT_SVH

// Property must hold at every edge out of reset.
`define SPTS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen out of reset.
`define SPTS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/spts_pkg.sv
// Shared constants, codes and types of the slotted page tuple store.
// No dependencies; compiled first.
package spts_pkg;

  localparam int PAGE_BYTES      = 4096;
  localparam int MAX_TUPLE_BYTES = 1024;
  localparam int MAX_SLOTS       = 1024;
  localparam int HDR_COUNT       = 8;
  localparam int HDR_FREE        = 10;
  localparam int SLOT_BASE       = 12;
  localparam int SLOT_SIZE       = 4;
  localparam int SLOT_SH         = $clog2(SLOT_SIZE);

  // derived widths
  localparam int PAW = $clog2(PAGE_BYTES);
  localparam int POW = PAW + 1;
  localparam int SIW = $clog2(MAX_SLOTS);
  localparam int SCW = SIW + 1;
  localparam int TLW = $clog2(MAX_TUPLE_BYTES) + 1;

  // transaction field widths
  localparam int OP_W   = 3;
  localparam int SLOT_W = 10;
  localparam int LEN_W  = 12;
  localparam int BYTE_W = 8;
  localparam int ADDR_W = 12;
  localparam int ST_W   = 2;
  localparam int TOFF_W = 13;
  localparam int TLEN_W = 12;
  localparam int FREE_W = 13;
  localparam int CNT_W  = 10;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_UPDATE = 3'd1,
    OP_BYTE   = 3'd2,
    OP_GET    = 3'd3,
    OP_REMOVE = 3'd4,
    OP_READ   = 3'd5,
    OP_FREE   = 3'd6,
    OP_NONE   = 3'd7
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEN  = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_NO_SLOT  = 2'd3
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  length;
    logic              len_bad;
    logic [BYTE_W-1:0] data_byte;
    logic [ADDR_W-1:0] address;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

  typedef struct packed {
    logic [POW-1:0] off;
    logic [TLW-1:0] len;
  } slot_t;

endpackage

// File: rtl/spts_if.sv
// Valid/ready channel interfaces for request and result transactions.
// Depends on spts_pkg for field widths.
interface spts_req_if;
  import spts_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [SLOT_W-1:0] slot;
  logic [LEN_W-1:0]  length;
  logic [BYTE_W-1:0] data_byte;
  logic [ADDR_W-1:0] address;
  modport source (output valid, op, slot, length, data_byte, address, input ready);
  modport sink   (input valid, op, slot, length, data_byte, address, output ready);
endinterface

interface spts_rsp_if;
  import spts_pkg::*;
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [SLOT_W-1:0] slot_out;
  logic [TOFF_W-1:0] tuple_offset;
  logic [TLEN_W-1:0] tuple_length;
  logic [BYTE_W-1:0] read_data;
  logic [FREE_W-1:0] free_bytes;
  logic [CNT_W-1:0]  slot_count;
  modport source (output valid, status, slot_out, tuple_offset, tuple_length, read_data,
                  free_bytes, slot_count, input ready);
  modport sink   (input valid, status, slot_out, tuple_offset, tuple_length, read_data,
                  free_bytes, slot_count, output ready);
endinterface

// File: rtl/spts_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package needed.
module spts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: rtl/spts_front.sv
// Front end: accepts request transactions, classifies them and queues commands.
// Depends on spts_pkg and spts_if.
module spts_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  spts_req_if.sink                 in_i,
  input  spts_pkg::back_stat_t     stat_i,
  output spts_pkg::queue_head_t    head_o
);
  import spts_pkg::*;

  localparam int QD  = 2;
  localparam int QAW = $clog2(QD);

  cmd_t            mem_q [QD];
  logic [QAW-1:0]  wr_q, rd_q;
  logic [QAW:0]    cnt_q;
  logic            push, pop;
  cmd_t            entry;

  assign in_i.ready = (cnt_q != (QAW+1)'(QD)) && !stat_i.clearing;

  always_comb begin
    entry.op        = op_e'(in_i.op);
    entry.slot      = in_i.slot;
    entry.length    = in_i.length;
    entry.len_bad   = (in_i.length == '0) || (32'(in_i.length) > MAX_TUPLE_BYTES);
    entry.data_byte = in_i.data_byte;
    entry.address   = in_i.address;
  end

  // unused op code is dropped here and never reaches the back end
  assign push = in_i.valid && in_i.ready && (entry.op != OP_NONE);
  assign pop  = stat_i.pop && (cnt_q != '0);

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rd_q];
endmodule

// File: rtl/spts_back.sv
// Back end: executes queued commands against page, slot and scratch memories,
// compacts the page when needed and holds the result register.
// Depends on spts_pkg, spts_if, spts_ram and the assertion header.
module spts_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  spts_pkg::queue_head_t  head_i,
  output spts_pkg::back_stat_t   stat_o,
  spts_rsp_if.source             out_o
);
  import spts_pkg::*;
  `include "slotted_page_tuple_store_core_assert.svh"

  typedef enum logic [12:0] {
    S_CLEAR    = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_LOOK     = 13'b0000000000100,
    S_READ     = 13'b0000000001000,
    S_SCAN_RD  = 13'b0000000010000,
    S_SCAN_CHK = 13'b0000000100000,
    S_PLACE    = 13'b0000001000000,
    S_CMP_RD   = 13'b0000010000000,
    S_CMP_CHK  = 13'b0000100000000,
    S_CMP_COPY = 13'b0001000000000,
    S_CPB      = 13'b0010000000000,
    S_ALLOC    = 13'b0100000000000,
    S_EMIT     = 13'b1000000000000
  } state_e;

  state_e          state_q, state_d;
  cmd_t            cmd_q, cmd_d;
  logic [SCW-1:0]  slot_total_q, slot_total_d;
  logic [POW-1:0]  free_start_q, free_start_d;
  logic [POW-1:0]  cursor_q, cursor_d;
  logic [LEN_W-1:0] pending_q, pending_d;
  logic [POW-1:0]  live_q, live_d;
  logic [PAW:0]    clr_q, clr_d;
  logic [SCW-1:0]  idx_q, idx_d;
  logic            found_q, found_d;
  logic [SIW-1:0]  target_q, target_d;
  logic            append_q, append_d;
  logic [POW-1:0]  need_q, need_d;
  logic [POW-1:0]  pos_q, pos_d;
  logic [POW-1:0]  src_q, src_d;
  logic [POW-1:0]  dst_q, dst_d;
  logic [TLW-1:0]  k_q, k_d;
  logic [TLW-1:0]  cnt_q, cnt_d;
  logic            oob_q, oob_d;
  logic [POW-1:0]  cpb_q, cpb_d;
  logic [POW-1:0]  cpw_q, cpw_d;
  logic            cpv_q, cpv_d;

  status_e           res_st_q, res_st_d;
  logic [SLOT_W-1:0] res_slot_q, res_slot_d;
  logic [TOFF_W-1:0] res_toff_q, res_toff_d;
  logic [TLEN_W-1:0] res_tlen_q, res_tlen_d;
  logic [BYTE_W-1:0] res_rdat_q, res_rdat_d;

  logic              out_valid_q, out_valid_d;
  status_e           out_st_q, out_st_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [TOFF_W-1:0] out_toff_q, out_toff_d;
  logic [TLEN_W-1:0] out_tlen_q, out_tlen_d;
  logic [BYTE_W-1:0] out_rdat_q, out_rdat_d;
  logic [FREE_W-1:0] out_free_q, out_free_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;

  // memory ports
  logic              pg_we, sc_we, sl_we;
  logic [PAW-1:0]    pg_waddr, pg_raddr, sc_waddr, sc_raddr;
  logic [BYTE_W-1:0] pg_wdata, pg_rdata, sc_wdata, sc_rdata;
  logic [SIW-1:0]    sl_waddr, sl_raddr;
  slot_t             sl_wdata, sl_rdata;
  logic              pop;

  // free space bookkeeping
  logic [POW:0]      slot_end, free_ext, total_free;
  logic [POW-1:0]    contig, area, dead;
  logic [POW+1:0]    upd_room;
  logic [ADDR_W-1:0] hd_rel, cq_rel;
  logic              cq_in_slots;
  logic [15:0]       slot_w16, cnt16, free16;
  logic [POW:0]      copy_src;
  logic [POW-1:0]    alloc_off;

  assign slot_end   = (POW+1)'(SLOT_BASE) + ((POW+1)'(slot_total_q) << SLOT_SH);
  assign free_ext   = (POW+1)'(free_start_q);
  assign contig     = (free_ext > slot_end) ? POW'(free_ext - slot_end) : '0;
  assign area       = POW'(PAGE_BYTES) - free_start_q;
  assign dead       = (area > live_q) ? area - live_q : '0;
  assign total_free = (POW+1)'(contig) + (POW+1)'(dead);
  assign upd_room   = (POW+2)'(total_free) + (POW+2)'(sl_rdata.len);
  assign alloc_off  = free_start_q - POW'(cmd_q.length);
  assign copy_src   = (POW+1)'(src_q) + (POW+1)'(k_q);

  assign hd_rel      = head_i.cmd.address - ADDR_W'(SLOT_BASE);
  assign cq_rel      = cmd_q.address - ADDR_W'(SLOT_BASE);
  assign cq_in_slots = (32'(cmd_q.address) >= SLOT_BASE) &&
                       ((POW+1)'(cmd_q.address) < slot_end);
  assign slot_w16    = cq_rel[1] ? 16'(sl_rdata.len) : 16'(sl_rdata.off);
  assign cnt16       = 16'(slot_total_q);
  assign free16      = 16'(free_start_q);

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    slot_total_d = slot_total_q;
    free_start_d = free_start_q;
    cursor_d     = cursor_q;
    pending_d    = pending_q;
    live_d       = live_q;
    clr_d        = clr_q;
    idx_d        = idx_q;
    found_d      = found_q;
    target_d     = target_q;
    append_d     = append_q;
    need_d       = need_q;
    pos_d        = pos_q;
    src_d        = src_q;
    dst_d        = dst_q;
    k_d          = k_q;
    cnt_d        = cnt_q;
    oob_d        = oob_q;
    cpb_d        = cpb_q;
    cpw_d        = cpw_q;
    cpv_d        = cpv_q;
    res_st_d     = res_st_q;
    res_slot_d   = res_slot_q;
    res_toff_d   = res_toff_q;
    res_tlen_d   = res_tlen_q;
    res_rdat_d   = res_rdat_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_st_d     = out_st_q;
    out_slot_d   = out_slot_q;
    out_toff_d   = out_toff_q;
    out_tlen_d   = out_tlen_q;
    out_rdat_d   = out_rdat_q;
    out_free_d   = out_free_q;
    out_cnt_d    = out_cnt_q;
    pg_we    = 1'b0;
    pg_waddr = '0;
    pg_wdata = '0;
    pg_raddr = '0;
    sc_we    = 1'b0;
    sc_waddr = '0;
    sc_wdata = '0;
    sc_raddr = '0;
    sl_we    = 1'b0;
    sl_waddr = '0;
    sl_wdata = '0;
    sl_raddr = '0;
    pop      = 1'b0;

    case (state_q)
      S_CLEAR: begin
        pg_we    = 1'b1;
        pg_waddr = clr_q[PAW-1:0];
        clr_d    = clr_q + 1'b1;
        if (32'(clr_q) == PAGE_BYTES - 1) state_d = S_IDLE;
      end

      S_IDLE: begin
        if (head_i.valid) begin
          pop        = 1'b1;
          cmd_d      = head_i.cmd;
          res_st_d   = ST_OK;
          res_slot_d = '0;
          res_toff_d = '0;
          res_tlen_d = '0;
          res_rdat_d = '0;
          found_d    = 1'b0;
          idx_d      = '0;
          case (head_i.cmd.op)
            OP_BYTE: begin
              // stray byte with nothing pending is dropped
              if (pending_q != '0) begin
                pg_we     = (32'(cursor_q) < PAGE_BYTES);
                pg_waddr  = PAW'(cursor_q);
                pg_wdata  = head_i.cmd.data_byte;
                cursor_d  = cursor_q + 1'b1;
                pending_d = pending_q - 1'b1;
              end
            end
            OP_INSERT: begin
              pending_d = '0;
              if (head_i.cmd.len_bad) begin
                res_st_d = ST_BAD_LEN;
                state_d  = S_EMIT;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            OP_UPDATE, OP_GET, OP_REMOVE: begin
              if (head_i.cmd.op != OP_GET) pending_d = '0;
              res_slot_d = head_i.cmd.slot;
              sl_raddr   = SIW'(head_i.cmd.slot);
              if ((SCW+1)'(head_i.cmd.slot) >= (SCW+1)'(slot_total_q)) begin
                res_st_d = ST_NO_SLOT;
                state_d  = S_EMIT;
              end else begin
                state_d = S_LOOK;
              end
            end
            OP_READ: begin
              pg_raddr = PAW'(head_i.cmd.address);
              sl_raddr = SIW'(hd_rel >> SLOT_SH);
              state_d  = S_READ;
            end
            OP_FREE: begin
              state_d = S_EMIT;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_READ: begin
        if (32'(cmd_q.address) >= PAGE_BYTES || 32'(cmd_q.address) < HDR_COUNT) begin
          res_rdat_d = '0;
        end else if (32'(cmd_q.address) == HDR_COUNT) begin
          res_rdat_d = cnt16[7:0];
        end else if (32'(cmd_q.address) == HDR_COUNT + 1) begin
          res_rdat_d = cnt16[15:8];
        end else if (32'(cmd_q.address) == HDR_FREE) begin
          res_rdat_d = free16[7:0];
        end else if (32'(cmd_q.address) == HDR_FREE + 1) begin
          res_rdat_d = free16[15:8];
        end else if (cq_in_slots) begin
          res_rdat_d = cq_rel[0] ? slot_w16[15:8] : slot_w16[7:0];
        end else begin
          res_rdat_d = pg_rdata;
        end
        state_d = S_EMIT;
      end

      S_LOOK: begin
        state_d  = S_EMIT;
        sl_waddr = SIW'(cmd_q.slot);
        if (sl_rdata.len == '0) begin
          res_st_d = ST_NO_SLOT;
        end else begin
          case (cmd_q.op)
            OP_GET: begin
              res_toff_d = TOFF_W'(sl_rdata.off);
              res_tlen_d = TLEN_W'(sl_rdata.len);
            end
            OP_REMOVE: begin
              sl_we  = 1'b1;
              live_d = live_q - POW'(sl_rdata.len);
            end
            default: begin
              if (cmd_q.len_bad) begin
                res_st_d = ST_BAD_LEN;
              end else if (cmd_q.length <= LEN_W'(sl_rdata.len)) begin
                // shrinking update stays in place
                sl_we        = 1'b1;
                sl_wdata.off = sl_rdata.off;
                sl_wdata.len = TLW'(cmd_q.length);
                live_d       = live_q - POW'(sl_rdata.len) + POW'(cmd_q.length);
                cursor_d     = sl_rdata.off;
                pending_d    = cmd_q.length;
                res_toff_d   = TOFF_W'(sl_rdata.off);
              end else if (upd_room < (POW+2)'(cmd_q.length)) begin
                res_st_d = ST_NO_SPACE;
              end else begin
                // tombstone, then reallocate
                sl_we    = 1'b1;
                live_d   = live_q - POW'(sl_rdata.len);
                target_d = SIW'(cmd_q.slot);
                append_d = 1'b0;
                need_d   = POW'(cmd_q.length);
                if (contig < POW'(cmd_q.length)) begin
                  pos_d   = POW'(PAGE_BYTES);
                  state_d = S_CMP_RD;
                end else begin
                  state_d = S_ALLOC;
                end
              end
            end
          endcase
        end
      end

      S_SCAN_RD: begin
        sl_raddr = SIW'(idx_q);
        state_d  = (idx_q == slot_total_q) ? S_PLACE : S_SCAN_CHK;
      end

      S_SCAN_CHK: begin
        if (sl_rdata.len == '0) begin
          found_d  = 1'b1;
          target_d = SIW'(idx_q);
          state_d  = S_PLACE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SCAN_RD;
        end
      end

      S_PLACE: begin
        need_d   = POW'(cmd_q.length) + (found_q ? '0 : POW'(SLOT_SIZE));
        append_d = !found_q;
        if (!found_q) target_d = SIW'(slot_total_q);
        if (!found_q && 32'(slot_total_q) >= MAX_SLOTS) begin
          res_st_d = ST_NO_SPACE;
          state_d  = S_EMIT;
        end else if (contig < need_d) begin
          if (total_free < (POW+1)'(need_d)) begin
            res_st_d = ST_NO_SPACE;
            state_d  = S_EMIT;
          end else begin
            idx_d   = '0;
            pos_d   = POW'(PAGE_BYTES);
            state_d = S_CMP_RD;
          end
        end else begin
          state_d = S_ALLOC;
        end
      end

      S_CMP_RD: begin
        sl_raddr = SIW'(idx_q);
        if (idx_q == slot_total_q) begin
          cpb_d   = pos_q;
          cpv_d   = 1'b0;
          state_d = S_CPB;
        end else begin
          state_d = S_CMP_CHK;
        end
      end

      S_CMP_CHK: begin
        if (sl_rdata.len == '0 || POW'(sl_rdata.len) > pos_q) begin
          idx_d   = idx_q + 1'b1;
          state_d = S_CMP_RD;
        end else begin
          sl_we        = 1'b1;
          sl_waddr     = SIW'(idx_q);
          sl_wdata.off = pos_q - POW'(sl_rdata.len);
          sl_wdata.len = sl_rdata.len;
          pos_d        = pos_q - POW'(sl_rdata.len);
          src_d        = sl_rdata.off;
          dst_d        = pos_q - POW'(sl_rdata.len);
          k_d          = '0;
          cnt_d        = sl_rdata.len;
          state_d      = S_CMP_COPY;
        end
      end

      S_CMP_COPY: begin
        // read byte k while writing byte k-1 into scratch
        if (k_q != '0) begin
          sc_we    = 1'b1;
          sc_waddr = PAW'(dst_q + POW'(k_q) - 1'b1);
          sc_wdata = oob_q ? '0 : pg_rdata;
        end
        if (k_q == cnt_q) begin
          idx_d   = idx_q + 1'b1;
          state_d = S_CMP_RD;
        end else begin
          pg_raddr = PAW'(copy_src);
          oob_d    = (32'(copy_src) >= PAGE_BYTES);
          k_d      = k_q + 1'b1;
        end
      end

      S_CPB: begin
        if (cpv_q) begin
          pg_we    = 1'b1;
          pg_waddr = PAW'(cpw_q);
          pg_wdata = sc_rdata;
        end
        if (32'(cpb_q) < PAGE_BYTES) begin
          sc_raddr = PAW'(cpb_q);
          cpw_d    = cpb_q;
          cpb_d    = cpb_q + 1'b1;
          cpv_d    = 1'b1;
        end else begin
          cpv_d = 1'b0;
          if (!cpv_q) begin
            free_start_d = pos_q;
            state_d      = S_ALLOC;
          end
        end
      end

      S_ALLOC: begin
        state_d = S_EMIT;
        if (contig < need_q) begin
          res_st_d = ST_NO_SPACE;
        end else begin
          free_start_d = alloc_off;
          cursor_d     = alloc_off;
          pending_d    = cmd_q.length;
          sl_we        = 1'b1;
          sl_waddr     = target_q;
          sl_wdata.off = alloc_off;
          sl_wdata.len = TLW'(cmd_q.length);
          live_d       = live_q + POW'(cmd_q.length);
          if (append_q) slot_total_d = slot_total_q + 1'b1;
          res_toff_d   = TOFF_W'(alloc_off);
          res_slot_d   = SLOT_W'(target_q);
        end
      end

      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_slot_d  = res_slot_q;
          out_toff_d  = res_toff_q;
          out_tlen_d  = res_tlen_q;
          out_rdat_d  = res_rdat_q;
          out_free_d  = FREE_W'(total_free);
          out_cnt_d   = CNT_W'(slot_total_q);
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      slot_total_q <= '0;
      free_start_q <= POW'(PAGE_BYTES);
      cursor_q     <= '0;
      pending_q    <= '0;
      live_q       <= '0;
      clr_q        <= '0;
      idx_q        <= '0;
      found_q      <= 1'b0;
      append_q     <= 1'b0;
      k_q          <= '0;
      cnt_q        <= '0;
      cpv_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      slot_total_q <= slot_total_d;
      free_start_q <= free_start_d;
      cursor_q     <= cursor_d;
      pending_q    <= pending_d;
      live_q       <= live_d;
      clr_q        <= clr_d;
      idx_q        <= idx_d;
      found_q      <= found_d;
      append_q     <= append_d;
      k_q          <= k_d;
      cnt_q        <= cnt_d;
      cpv_q        <= cpv_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    target_q   <= target_d;
    need_q     <= need_d;
    pos_q      <= pos_d;
    src_q      <= src_d;
    dst_q      <= dst_d;
    oob_q      <= oob_d;
    cpb_q      <= cpb_d;
    cpw_q      <= cpw_d;
    res_st_q   <= res_st_d;
    res_slot_q <= res_slot_d;
    res_toff_q <= res_toff_d;
    res_tlen_q <= res_tlen_d;
    res_rdat_q <= res_rdat_d;
    out_st_q   <= out_st_d;
    out_slot_q <= out_slot_d;
    out_toff_q <= out_toff_d;
    out_tlen_q <= out_tlen_d;
    out_rdat_q <= out_rdat_d;
    out_free_q <= out_free_d;
    out_cnt_q  <= out_cnt_d;
  end

  spts_ram #(.WIDTH(BYTE_W), .DEPTH(PAGE_BYTES)) u_page (
    .clk_i, .we_i(pg_we), .waddr_i(pg_waddr), .wdata_i(pg_wdata),
    .raddr_i(pg_raddr), .rdata_o(pg_rdata)
  );

  spts_ram #(.WIDTH(BYTE_W), .DEPTH(PAGE_BYTES)) u_scratch (
    .clk_i, .we_i(sc_we), .waddr_i(sc_waddr), .wdata_i(sc_wdata),
    .raddr_i(sc_raddr), .rdata_o(sc_rdata)
  );

  spts_ram #(.WIDTH($bits(slot_t)), .DEPTH(MAX_SLOTS)) u_slots (
    .clk_i, .we_i(sl_we), .waddr_i(sl_waddr), .wdata_i(sl_wdata),
    .raddr_i(sl_raddr), .rdata_o(sl_rdata)
  );

  assign stat_o.pop      = pop;
  assign stat_o.clearing = (state_q == S_CLEAR);

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_st_q;
  assign out_o.slot_out     = out_slot_q;
  assign out_o.tuple_offset = out_toff_q;
  assign out_o.tuple_length = out_tlen_q;
  assign out_o.read_data    = out_rdat_q;
  assign out_o.free_bytes   = out_free_q;
  assign out_o.slot_count   = out_cnt_q;

  `SPTS_ASSERT(a_free_above_slots, clk_i, rst_ni, free_ext >= slot_end, "tuple area overlaps slot array")
  `SPTS_ASSERT(a_live_in_area, clk_i, rst_ni, live_q <= area, "live tuple bytes exceed tuple area")
  `SPTS_ASSERT_NEVER(a_clear_quiet, clk_i, rst_ni, (state_q == S_CLEAR) && (pop || out_valid_q), "activity during clearing pass")
endmodule

// File: rtl/slotted_page_tuple_store_core.sv
// Tuple bytes are written from idle; get/remove/read pass through a lookup or read state
// to the result register, free goes to it directly. Insert scans the slots in turn;
// compaction copies live tuples to scratch, then the repacked area back. Queue of 2
// commands decouples acceptance. Reset: asynchronous, active low; then a clearing pass
// (one page byte per cycle through the page RAM write port) accepting no transaction.
// Top level of the slotted page tuple store; needs spts_pkg, spts_if, front and back.
module slotted_page_tuple_store_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  spts_req_if.sink    in_i,
  spts_rsp_if.source  out_o
);
  import spts_pkg::*;

  queue_head_t head;
  back_stat_t  stat;

  spts_front u_front (
    .clk_i, .rst_ni, .in_i, .stat_i(stat), .head_o(head)
  );

  spts_back u_back (
    .clk_i, .rst_ni, .head_i(head), .stat_o(stat), .out_o
  );
endmodule

// File: verif/slotted_page_tuple_store_core_test.sv
// Self-checking testbench for slotted_page_tuple_store_core: a directed table, then random
// transactions; results checked against typed rows or the page model. Needs spts_pkg, spts_if.
module slotted_page_tuple_store_core_test;
  import spts_pkg::*;

  localparam int RAND_ITEMS  = 1750;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] dbyte;
    logic [ADDR_W-1:0] addr;
  } req_t;

  typedef struct {
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] slot_out;
    logic [TOFF_W-1:0] toff;
    logic [TLEN_W-1:0] tlen;
    logic [BYTE_W-1:0] rdata;
    logic [FREE_W-1:0] free;
    logic [CNT_W-1:0]  count;
  } rsp_t;

  typedef struct {
    req_t rq;
    bit   typed;
    rsp_t want;
  } row_t;

  logic clk_i;
  logic rst_ni;
  spts_req_if req_bus ();
  spts_rsp_if rsp_bus ();

  slotted_page_tuple_store_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_bus),
    .out_o  (rsp_bus)
  );

  // page model
  logic [7:0]  page_mem [PAGE_BYTES];
  logic [7:0]  scratch_mem [PAGE_BYTES];
  int unsigned n_slots, free_start, wr_cursor, bytes_left;

  rsp_t        results_due [$];
  row_t        dir_rows [$];
  logic [7:0]  tuple_bytes_q [$];
  req_t        cur;
  int          errors, n_sent, rand_done, phase, cycles, n_results, n_compactions;
  bit          stim_done;

  function automatic int unsigned pg_rd(int unsigned a);
    return a < PAGE_BYTES ? page_mem[a] : 0;
  endfunction

  function automatic int unsigned rd16(int unsigned a);
    return pg_rd(a) | (pg_rd(a + 1) << 8);
  endfunction

  function automatic void wr16(int unsigned a, int unsigned v);
    if (a < PAGE_BYTES) page_mem[a] = v[7:0];
    if (a + 1 < PAGE_BYTES) page_mem[a + 1] = v[15:8];
  endfunction

  function automatic int unsigned slot_len(int unsigned i);
    return rd16(SLOT_BASE + i * SLOT_SIZE + 2);
  endfunction

  function automatic int unsigned slot_off(int unsigned i);
    return rd16(SLOT_BASE + i * SLOT_SIZE);
  endfunction

  function automatic void set_slot(int unsigned i, int unsigned off, int unsigned len);
    wr16(SLOT_BASE + i * SLOT_SIZE, off);
    wr16(SLOT_BASE + i * SLOT_SIZE + 2, len);
  endfunction

  function automatic int unsigned contig_free();
    int unsigned lim;
    lim = SLOT_BASE + n_slots * SLOT_SIZE;
    return free_start > lim ? free_start - lim : 0;
  endfunction

  function automatic int unsigned total_free();
    int unsigned live, area;
    live = 0;
    for (int unsigned i = 0; i < n_slots; i++) live += slot_len(i);
    area = free_start < PAGE_BYTES ? PAGE_BYTES - free_start : 0;
    return contig_free() + (area > live ? area - live : 0);
  endfunction

  // repack live tuples against the page end, slot order first-to-last
  function automatic void compact_page();
    int unsigned pos, len, off;
    pos = PAGE_BYTES;
    n_compactions++;
    for (int unsigned i = 0; i < n_slots; i++) begin
      len = slot_len(i);
      off = slot_off(i);
      if (len != 0 && len <= pos) begin
        pos -= len;
        for (int unsigned k = 0; k < len; k++) scratch_mem[pos + k] = pg_rd(off + k);
        set_slot(i, pos, len);
      end
    end
    for (int unsigned a = pos; a < PAGE_BYTES; a++) page_mem[a] = scratch_mem[a];
    free_start = pos;
  endfunction

  function automatic int unsigned claim_space(int unsigned len);
    free_start -= len;
    wr_cursor = free_start;
    bytes_left = len;
    return free_start;
  endfunction

  function automatic void store_reset();
    foreach (page_mem[a]) page_mem[a] = '0;
    n_slots = 0;
    free_start = PAGE_BYTES;
    wr_cursor = 0;
    bytes_left = 0;
    wr16(HDR_COUNT, 0);
    wr16(HDR_FREE, free_start);
  endfunction

  // returns 1 when the transaction yields a result
  function automatic bit store_step(input req_t r, output rsp_t o);
    int unsigned st, so, toff, tlen, rdat, len, cur_len, reuse, need;
    bit found;
    st = ST_OK; so = 0; toff = 0; tlen = 0; rdat = 0;
    len = r.length;
    o = '{default: '0};
    if (r.op == OP_BYTE) begin
      if (bytes_left != 0) begin
        if (wr_cursor < PAGE_BYTES) page_mem[wr_cursor] = r.dbyte;
        wr_cursor = (wr_cursor + 1) & 13'h1fff;
        bytes_left--;
      end
      return 0;
    end
    if (r.op == OP_NONE) return 0;
    if (r.op inside {OP_INSERT, OP_UPDATE, OP_REMOVE}) bytes_left = 0;
    if (r.op == OP_INSERT) begin
      if (len == 0 || len > MAX_TUPLE_BYTES) st = ST_BAD_LEN;
      else begin
        found = 0;
        reuse = 0;
        for (int unsigned i = 0; i < n_slots && !found; i++)
          if (slot_len(i) == 0) begin
            reuse = i;
            found = 1;
          end
        need = len + (found ? 0 : SLOT_SIZE);
        if (!found && n_slots >= MAX_SLOTS) st = ST_NO_SPACE;
        else if (contig_free() < need) begin
          if (total_free() < need) st = ST_NO_SPACE;
          else begin
            compact_page();
            if (contig_free() < need) st = ST_NO_SPACE;
          end
        end
        if (st == ST_OK) begin
          toff = claim_space(len);
          if (!found) begin
            reuse = n_slots;
            n_slots++;
          end
          set_slot(reuse, toff, len);
          so = reuse;
        end
      end
    end else if (r.op inside {OP_UPDATE, OP_GET, OP_REMOVE}) begin
      cur_len = r.slot < n_slots ? slot_len(r.slot) : 0;
      so = r.slot;
      if (cur_len == 0) st = ST_NO_SLOT;
      else if (r.op == OP_GET) begin
        toff = slot_off(r.slot);
        tlen = cur_len;
      end else if (r.op == OP_REMOVE) set_slot(r.slot, 0, 0);
      else if (len == 0 || len > MAX_TUPLE_BYTES) st = ST_BAD_LEN;
      else if (len <= cur_len) begin
        toff = slot_off(r.slot);
        set_slot(r.slot, toff, len);
        wr_cursor = toff;
        bytes_left = len;
      end else if (total_free() + cur_len < len) st = ST_NO_SPACE;
      else begin
        // growth: tombstone first, the slot stays dead if space still runs short
        set_slot(r.slot, 0, 0);
        if (contig_free() < len) compact_page();
        if (contig_free() < len) st = ST_NO_SPACE;
        else begin
          toff = claim_space(len);
          set_slot(r.slot, toff, len);
        end
      end
    end else if (r.op == OP_READ) rdat = pg_rd(r.addr);
    wr16(HDR_COUNT, n_slots);
    wr16(HDR_FREE, free_start);
    o.status = st;
    o.slot_out = so;
    o.toff = toff;
    o.tlen = tlen;
    o.rdata = rdat;
    o.free = total_free();
    o.count = n_slots;
    return 1;
  endfunction

  function automatic row_t mk(logic [OP_W-1:0] op, int slot, int len, int b, int addr,
                              bit typed = 0, int st = 0, int so = 0, int toff = 0,
                              int tlen = 0, int rd = 0, int fb = 0, int cnt = 0);
    row_t t;
    t.rq = '{op, slot, len, b, addr};
    t.typed = typed;
    t.want = '{st, so, toff, tlen, rd, fb, cnt};
    return t;
  endfunction

  function automatic int pick_len();
    int k;
    k = $urandom_range(99);
    if (k < 80) return $urandom_range(48, 1);
    if (k < 93) return $urandom_range(MAX_TUPLE_BYTES, 49);
    if (k < 96) return MAX_TUPLE_BYTES;
    return $urandom_range(1) ? 0 : $urandom_range(4095, MAX_TUPLE_BYTES + 1);
  endfunction

  // queue the tuple bytes; long tuples are cut short so their bytes get abandoned
  function automatic void queue_tuple(int len);
    int n;
    n = (len <= 48) ? len : $urandom_range(8);
    if (n > 0 && $urandom_range(9) == 0) n--;
    for (int i = 0; i < n; i++) tuple_bytes_q.push_back($urandom_range(255));
  endfunction

  function automatic req_t next_random();
    req_t r;
    int k;
    r = '{$urandom_range(7), $urandom_range(1023), $urandom_range(4095),
          $urandom_range(255), $urandom_range(4095)};
    if (tuple_bytes_q.size() > 0) begin
      r.op = OP_BYTE;
      r.dbyte = tuple_bytes_q.pop_front();
      rand_done++;
      return r;
    end
    if ($urandom_range(99) < 85) r.slot = $urandom_range(n_slots + 1);
    k = $urandom_range(99);
    rand_done++;
    if (k < 30) begin
      r.op = OP_INSERT;
      r.length = pick_len();
      queue_tuple(r.length);
    end else if (k < 42) begin
      r.op = OP_UPDATE;
      r.length = pick_len();
      queue_tuple(r.length);
    end else if (k < 55) r.op = OP_GET;
    else if (k < 75) r.op = OP_REMOVE;
    else if (k < 85) begin
      r.op = OP_READ;
      if ($urandom_range(1)) r.addr = $urandom_range(SLOT_BASE + 4 * n_slots + 3);
    end else if (k < 92) r.op = OP_FREE;
    else if (k < 96) begin
      r.op = OP_BYTE;       // stray byte, ignored unless a tuple still awaits bytes
      rand_done--;
    end else begin
      r.op = OP_NONE;
      rand_done--;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH result %0d %s: got %0d expected %0d", n_results, what, got, want);
    errors++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, results_due.size());
      $display("slotted_page_tuple_store_core_test NOT OK");
      $finish;
    end
  end

  // request side: hold while stalled, otherwise maybe idle, else present the next transaction
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t o;
    if (!rst_ni) req_bus.valid <= 1'b0;
    else begin
      if (req_bus.valid && req_bus.ready) begin
        if (store_step(cur, o)) begin
          if (n_sent <= dir_rows.size() && dir_rows[n_sent - 1].typed)
            o = dir_rows[n_sent - 1].want;
          results_due.push_back(o);
        end
      end
      if (!(req_bus.valid && !req_bus.ready)) begin
        if (n_sent >= dir_rows.size() && rand_done >= RAND_ITEMS && tuple_bytes_q.size() == 0)
          stim_done = 1;
        if (stim_done || ((phase == 1 || phase == 3) &&
                          $urandom_range(99) < (phase == 1 ? 62 : 33)))
          req_bus.valid <= 1'b0;
        else begin
          cur = n_sent < dir_rows.size() ? dir_rows[n_sent].rq : next_random();
          n_sent++;
          phase = n_sent <= dir_rows.size() ? 0 : rand_done * 4 / RAND_ITEMS;
          if (phase > 3) phase = 3;
          req_bus.valid     <= 1'b1;
          req_bus.op        <= cur.op;
          req_bus.slot      <= cur.slot;
          req_bus.length    <= cur.length;
          req_bus.data_byte <= cur.dbyte;
          req_bus.address   <= cur.addr;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    rsp_bus.ready <= (phase == 2 || phase == 3) ?
                     ($urandom_range(99) >= (phase == 2 ? 62 : 33)) : 1'b1;
  end

  always @(posedge clk_i) begin
    rsp_t w;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      n_results++;
      if (results_due.size() == 0) begin
        $display("unexpected result transaction %0d", n_results);
        errors++;
      end else begin
        w = results_due.pop_front();
        if (rsp_bus.status !== w.status) report_mismatch("status", rsp_bus.status, w.status);
        if (rsp_bus.slot_out !== w.slot_out) report_mismatch("slot_out", rsp_bus.slot_out, w.slot_out);
        if (rsp_bus.tuple_offset !== w.toff)
          report_mismatch("tuple_offset", rsp_bus.tuple_offset, w.toff);
        if (rsp_bus.tuple_length !== w.tlen)
          report_mismatch("tuple_length", rsp_bus.tuple_length, w.tlen);
        if (rsp_bus.read_data !== w.rdata) report_mismatch("read_data", rsp_bus.read_data, w.rdata);
        if (rsp_bus.free_bytes !== w.free) report_mismatch("free_bytes", rsp_bus.free_bytes, w.free);
        if (rsp_bus.slot_count !== w.count) report_mismatch("slot_count", rsp_bus.slot_count, w.count);
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.op = OP_NONE;
    req_bus.slot = '0;
    req_bus.length = '0;
    req_bus.data_byte = '0;
    req_bus.address = '0;
    rsp_bus.ready = 1'b0;
    store_reset();
    // op, slot, length, byte, address, typed, status, slot_out, offset, length, data, free, count
    dir_rows = '{
      mk(OP_FREE,      0,    0,   0,    0, 1, ST_OK,       0, 0, 0, 0, 4084, 0),
      mk(OP_READ,      0,    0,   0,   11, 1, ST_OK,       0, 0, 0, 8'h10, 4084, 0),
      mk(OP_GET,       0,    0,   0,    0, 1, ST_NO_SLOT,  0, 0, 0, 0, 4084, 0),
      mk(OP_INSERT,    0,    0,   0,    0, 1, ST_BAD_LEN,  0, 0, 0, 0, 4084, 0),
      mk(OP_INSERT,    0, 1025,   0,    0, 1, ST_BAD_LEN,  0, 0, 0, 0, 4084, 0),
      mk(OP_INSERT,    0, 4095,   0,    0, 1, ST_BAD_LEN,  0, 0, 0, 0, 4084, 0),
      mk(OP_UPDATE, 1023,   10,   0,    0, 1, ST_NO_SLOT, 1023, 0, 0, 0, 4084, 0),
      mk(OP_REMOVE,    5,    0,   0,    0, 1, ST_NO_SLOT,  5, 0, 0, 0, 4084, 0),
      mk(OP_INSERT,    0, 1024,   0,    0, 1, ST_OK,       0, 3072, 0, 0, 3056, 1),
      mk(OP_BYTE,      0,    0, 255,    0),
      mk(OP_BYTE,      0,    0,   0,    0),
      mk(OP_BYTE,      0,    0, 8'h5a,  0),
      mk(OP_INSERT,    0,    1,   0,    0, 1, ST_OK,       1, 3071, 0, 0, 3051, 2),
      mk(OP_BYTE,      0,    0, 8'haa,  0),
      mk(OP_BYTE,      0,    0, 8'h55,  0),
      mk(OP_READ,      0,    0,   0, 3071, 1, ST_OK,       0, 0, 0, 8'haa, 3051, 2),
      mk(OP_READ,      0,    0,   0, 3072, 1, ST_OK,       0, 0, 0, 8'hff, 3051, 2),
      mk(OP_GET,       1,    0,   0,    0, 1, ST_OK,       1, 3071, 1, 0, 3051, 2),
      mk(OP_UPDATE,    1,    0,   0,    0, 1, ST_BAD_LEN,  1, 0, 0, 0, 3051, 2),
      mk(OP_UPDATE,    0,   10,   0,    0),
      mk(OP_UPDATE,    1,  500,   0,    0),
      mk(OP_REMOVE,    0,    0,   0,    0),
      mk(OP_INSERT,    0, 1000,   0,    0),
      mk(OP_NONE,      0,    0,   0,    0),
      mk(OP_READ,      0,    0,   0, 4095)
    };
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the block clears its page after reset; the handshake covers that wait
    do @(posedge clk_i); while (!stim_done || req_bus.valid || results_due.size() != 0);
    repeat (300) @(posedge clk_i);
    $display("%0d transactions sent, %0d results checked, %0d compactions, %0d slots at end",
             n_sent, n_results, n_compactions, n_slots);
    if (errors == 0 && results_due.size() == 0) $display("slotted_page_tuple_store_core_test OK");
    else $display("slotted_page_tuple_store_core_test NOT OK");
    $finish;
  end

endmodule
